// ===== rtl/sipi_pkg.sv =====
`default_nettype none

package sipi_pkg;

    localparam int COUNT_LIMIT = 63;
    localparam int CNT_W = $clog2(COUNT_LIMIT + 1);
    localparam int ADDR_BYTES_W = 3;
    localparam int LEN_W = 6;
    localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W + 1 : LEN_W + 1;
    localparam int HDR_LEN = 2;
    localparam int CRC_LEN = 2;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam logic [4:0] CMD_READ_WRITE_LONG = 5'h0A;
    localparam logic [4:0] CMD_ID_REQUEST = 5'h12;
    localparam logic [4:0] CMD_STREAM_WRITE = 5'h17;

    typedef enum logic [2:0] {
        KIND_HDR_HI  = 3'd0,
        KIND_HDR_LO  = 3'd1,
        KIND_ADDR    = 3'd2,
        KIND_DATA    = 3'd3,
        KIND_CRC_HI  = 3'd4,
        KIND_CRC_LO  = 3'd5,
        KIND_SURPLUS = 3'd6
    } byte_kind_t;

    typedef enum logic [2:0] {
        STATUS_OK          = 3'd0,
        STATUS_MISMATCH    = 3'd1,
        STATUS_INCOMPLETE  = 3'd2,
        STATUS_HEADER_ONLY = 3'd3,
        STATUS_TOO_SHORT   = 3'd4
    } frame_status_t;

    typedef struct packed {
        byte_kind_t    byte_kind;
        logic [2:0]    tag;
        logic [4:0]    command;
        logic          command_known;
        logic [2:0]    channel;
        logic          reserved_mid_warning;
        logic          reserved_low_warning;
        logic          frame_done;
        frame_status_t frame_status;
        logic [15:0]   computed_crc;
        logic [15:0]   received_crc;
    } result_t;

    function automatic logic cmd_known(input logic [4:0] cmd);
        logic known;
        unique case (cmd)
            5'h00, 5'h01, 5'h02,
            5'h04, 5'h05, 5'h06,
            5'h08, 5'h09, CMD_READ_WRITE_LONG,
            5'h0C, CMD_ID_REQUEST, CMD_STREAM_WRITE: known = 1'b1;
            default: known = 1'b0;
        endcase
        return known;
    endfunction

    function automatic logic [ADDR_BYTES_W-1:0] cmd_addr_bytes(input logic [4:0] cmd);
        logic [ADDR_BYTES_W-1:0] len;
        unique case (cmd)
            5'h00, 5'h01, 5'h02,
            5'h04, 5'h05, 5'h06,
            CMD_READ_WRITE_LONG: len = ADDR_BYTES_W'(4);
            default: len = '0;
        endcase
        return len;
    endfunction

    function automatic logic [LEN_W-1:0] cmd_data_len(input logic [4:0] cmd);
        logic [LEN_W-1:0] len;
        unique case (cmd)
            5'h04, 5'h05, 5'h06,
            CMD_READ_WRITE_LONG: len = LEN_W'(4);
            CMD_STREAM_WRITE: len = LEN_W'(32);
            default: len = '0;
        endcase
        return len;
    endfunction

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sipi_if.sv =====
`default_nettype none

interface sipi_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       frame_end;

    modport source (output valid, output byte_value, output frame_end, input ready);
    modport sink (input valid, input byte_value, input frame_end, output ready);
endinterface

interface sipi_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  byte_kind;
    logic [2:0]  tag;
    logic [4:0]  command;
    logic        command_known;
    logic [2:0]  channel;
    logic        reserved_mid_warning;
    logic        reserved_low_warning;
    logic        frame_done;
    logic [2:0]  frame_status;
    logic [15:0] computed_crc;
    logic [15:0] received_crc;

    modport source (
        output valid, output byte_kind, output tag, output command, output command_known,
        output channel, output reserved_mid_warning, output reserved_low_warning,
        output frame_done, output frame_status, output computed_crc, output received_crc,
        input ready
    );
    modport sink (
        input valid, input byte_kind, input tag, input command, input command_known,
        input channel, input reserved_mid_warning, input reserved_low_warning,
        input frame_done, input frame_status, input computed_crc, input received_crc,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/sipi_frame_parser.sv =====
// Each accepted byte's result is registered in a two-entry output buffer (output
// or, while the output stalls, skid register). Throughput: one byte per cycle
// while the buffer has room; the frame state and the byte-wide CRC update
// combinationally, and the buffer keeps input flowing while a result waits.
// Reset clears the frame state: position zero, CRC all ones, empty buffer.
`default_nettype none

module sipi_frame_parser (
    input wire logic      clk,
    input wire logic      rst_n,
    sipi_byte_if.sink     bytes,
    sipi_result_if.source results
);

    localparam int CNT_W = sipi_pkg::CNT_W;
    localparam int CMP_W = sipi_pkg::CMP_W;
    localparam int LEN_W = sipi_pkg::LEN_W;
    localparam int ADDR_BYTES_W = sipi_pkg::ADDR_BYTES_W;

    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [LEN_W-1:0]        exp_len_reg, exp_len_next;
    logic [ADDR_BYTES_W-1:0] addr_bytes_reg, addr_bytes_next;
    logic [LEN_W-1:0]        data_len;
    logic [15:0]             crc_reg, crc_next;
    logic [15:0]             got_reg, got_next;
    logic [15:0]             hdr_reg, hdr_next;

    logic                    accept;
    logic                    buf_ready;
    logic [7:0]              b;
    logic [CMP_W-1:0]        pos_w;
    logic [CMP_W-1:0]        exp_w;
    logic [CMP_W-1:0]        n_w;
    sipi_pkg::result_t       res;
    sipi_pkg::result_t       res_out;
    logic                    res_valid;

    assign b      = bytes.byte_value;
    assign accept = bytes.valid && buf_ready;
    assign bytes.ready = buf_ready;

    always_comb
    begin
        hdr_next        = hdr_reg;
        addr_bytes_next = addr_bytes_reg;
        data_len        = '0;
        exp_len_next    = exp_len_reg;
        if (cnt_reg == '0)
        begin
            hdr_next        = {b, 8'h00};
            addr_bytes_next = sipi_pkg::cmd_addr_bytes(b[4:0]);
            data_len        = sipi_pkg::cmd_data_len(b[4:0]);
            exp_len_next    = LEN_W'(sipi_pkg::HDR_LEN + sipi_pkg::CRC_LEN)
                              + LEN_W'(addr_bytes_next) + data_len;
        end
        else if (cnt_reg == CNT_W'(1))
        begin
            hdr_next = {hdr_reg[15:8], b};
        end

        pos_w = CMP_W'(cnt_reg);
        exp_w = CMP_W'(exp_len_next);
        n_w   = pos_w + CMP_W'(1);

        if (pos_w == '0)
        begin
            res.byte_kind = sipi_pkg::KIND_HDR_HI;
        end
        else if (pos_w == CMP_W'(1))
        begin
            res.byte_kind = sipi_pkg::KIND_HDR_LO;
        end
        else if (pos_w < CMP_W'(sipi_pkg::HDR_LEN) + CMP_W'(addr_bytes_next))
        begin
            res.byte_kind = sipi_pkg::KIND_ADDR;
        end
        else if (pos_w < exp_w - CMP_W'(sipi_pkg::CRC_LEN))
        begin
            res.byte_kind = sipi_pkg::KIND_DATA;
        end
        else if (pos_w == exp_w - CMP_W'(sipi_pkg::CRC_LEN))
        begin
            res.byte_kind = sipi_pkg::KIND_CRC_HI;
        end
        else if (pos_w == exp_w - CMP_W'(1))
        begin
            res.byte_kind = sipi_pkg::KIND_CRC_LO;
        end
        else
        begin
            res.byte_kind = sipi_pkg::KIND_SURPLUS;
        end

        crc_next = crc_reg;
        got_next = got_reg;
        if (pos_w < exp_w - CMP_W'(sipi_pkg::CRC_LEN))
        begin
            crc_next = sipi_pkg::crc_byte(crc_reg, b);
        end
        else if (res.byte_kind == sipi_pkg::KIND_CRC_HI)
        begin
            got_next = {b, got_reg[7:0]};
        end
        else if (res.byte_kind == sipi_pkg::KIND_CRC_LO)
        begin
            got_next = {got_reg[15:8], b};
        end

        res.tag                  = hdr_next[15:13];
        res.command              = hdr_next[12:8];
        res.command_known        = sipi_pkg::cmd_known(hdr_next[12:8]);
        res.channel              = hdr_next[3:1];
        res.reserved_mid_warning = |hdr_next[7:4];
        res.reserved_low_warning = hdr_next[0];
        res.frame_done           = bytes.frame_end;
        res.frame_status         = sipi_pkg::STATUS_OK;
        res.computed_crc         = '0;
        res.received_crc         = '0;

        if (bytes.frame_end)
        begin
            priority if (n_w < CMP_W'(sipi_pkg::HDR_LEN))
            begin
                res.frame_status = sipi_pkg::STATUS_TOO_SHORT;
            end
            else if (n_w == CMP_W'(sipi_pkg::HDR_LEN))
            begin
                res.frame_status = sipi_pkg::STATUS_HEADER_ONLY;
            end
            else if (n_w < exp_w)
            begin
                res.frame_status = sipi_pkg::STATUS_INCOMPLETE;
            end
            else
            begin
                res.computed_crc = crc_next;
                res.received_crc = got_next;
                res.frame_status = (crc_next == got_next) ? sipi_pkg::STATUS_OK
                                                          : sipi_pkg::STATUS_MISMATCH;
            end
        end

        if (cnt_reg < CNT_W'(sipi_pkg::COUNT_LIMIT))
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            exp_len_reg    <= LEN_W'(sipi_pkg::HDR_LEN + sipi_pkg::CRC_LEN);
            addr_bytes_reg <= '0;
            crc_reg        <= sipi_pkg::CRC_INIT;
            got_reg        <= '0;
            hdr_reg        <= '0;
        end
        else if (accept)
        begin
            if (bytes.frame_end)
            begin
                cnt_reg        <= '0;
                exp_len_reg    <= LEN_W'(sipi_pkg::HDR_LEN + sipi_pkg::CRC_LEN);
                addr_bytes_reg <= '0;
                crc_reg        <= sipi_pkg::CRC_INIT;
                got_reg        <= '0;
                hdr_reg        <= '0;
            end
            else
            begin
                cnt_reg        <= cnt_next;
                exp_len_reg    <= exp_len_next;
                addr_bytes_reg <= addr_bytes_next;
                crc_reg        <= crc_next;
                got_reg        <= got_next;
                hdr_reg        <= hdr_next;
            end
        end
    end

    sipi_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (bytes.valid),
        .in_ready  (buf_ready),
        .in_data   (res),
        .out_valid (res_valid),
        .out_ready (results.ready),
        .out_data  (res_out)
    );

    assign results.valid                = res_valid;
    assign results.byte_kind            = res_out.byte_kind;
    assign results.tag                  = res_out.tag;
    assign results.command              = res_out.command;
    assign results.command_known        = res_out.command_known;
    assign results.channel              = res_out.channel;
    assign results.reserved_mid_warning = res_out.reserved_mid_warning;
    assign results.reserved_low_warning = res_out.reserved_low_warning;
    assign results.frame_done           = res_out.frame_done;
    assign results.frame_status         = res_out.frame_status;
    assign results.computed_crc         = res_out.computed_crc;
    assign results.received_crc         = res_out.received_crc;

endmodule

`default_nettype wire

// ===== rtl/sipi_skid.sv =====
`default_nettype none

module sipi_skid (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire sipi_pkg::result_t in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output sipi_pkg::result_t     out_data
);

    logic              out_valid_reg;
    logic              skid_valid_reg;
    sipi_pkg::result_t out_data_reg;
    sipi_pkg::result_t skid_data_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else begin
                out_valid_reg <= in_valid;
            end
        end
        else if (in_valid && !skid_valid_reg) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk) begin
        if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
            end
            else begin
                out_data_reg <= in_data;
            end
        end
        else if (in_valid && !skid_valid_reg) begin
            skid_data_reg <= in_data;
        end
    end

endmodule

`default_nettype wire
